// ===== rtl/dtbl_pkg.sv =====
// ----------------------------------------------------------------------------
// dtbl_pkg
// Shared types and constants for the dual token bucket limiter.
// ----------------------------------------------------------------------------
package dtbl_pkg;

   // default parameter values
   localparam int COUNT_BITS_DEF = 20;
   localparam int SIZE_BITS_DEF  = 48;
   localparam int TIME_BITS_DEF  = 16;

   // fixed field and port widths
   localparam int WAIT_BITS   = 16;
   localparam int PERIOD_BITS = 16;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 5;
   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 8;
   localparam int RSP_TUSER_W = 1;

   // reset values
   localparam int COUNT_RESET  = 100;
   localparam int PERIOD_RESET = 1000;
   localparam int WAIT_RESET   = 3600;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_REQUEST = 2'd1,
      OP_RELOAD  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      REG_COUNT_CAP  = 2'd0,
      REG_SIZE_CAP   = 2'd1,
      REG_PERIOD     = 2'd2,
      REG_WAIT_LIMIT = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic decision;
      logic forced_release;
   } verdict_type;

endpackage

// ===== rtl/dual_token_bucket_limiter.sv =====
// ----------------------------------------------------------------------------
// dual_token_bucket_limiter
// Rate limiter with an operation-count bucket and a byte bucket.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one operation per transfer: tuser[1:0] is the operation
//   (tick, request, reload), tuser[2] flags a valid size, tdata the size.
//   Every request gives one rsp_* transfer: tdata[0] is the decision
//   (0 grant, 1 delay), tuser[0] marks a forced release. Ticks and reloads
//   update state only, unknown operations change nothing, and none gives a transfer.
//   csr_* is an APB-style port with 64-bit registers at 8-byte strides;
//   write it only while no item is in flight.
// Timing:
//   an accepted item is held in the input register; its decision is computed
//   combinationally from it and loaded into the result register, which drives
//   rsp_tvalid. One item per cycle is sustained unless a held result blocks a
//   request; the bucket update is a single pass of adds and compares.
// Reset and stall:
//   reset restores register and bucket defaults and empties both stages.
//   While rsp_tready is low a held result blocks only the next request;
//   one more item is still taken into the input register.
// ----------------------------------------------------------------------------
module dual_token_bucket_limiter #(
   parameter int COUNT_BITS = dtbl_pkg::COUNT_BITS_DEF,
   parameter int SIZE_BITS  = dtbl_pkg::SIZE_BITS_DEF,
   parameter int TIME_BITS  = dtbl_pkg::TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dtbl_pkg::REQ_TDATA_W-1:0]   req_tdata,  // request_size
   input  logic [dtbl_pkg::REQ_TUSER_W-1:0]   req_tuser,  // operation[1:0], has_size
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dtbl_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // decision, zero pad
   output logic [dtbl_pkg::RSP_TUSER_W-1:0]   rsp_tuser,  // forced_release
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dtbl_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dtbl_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dtbl_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import dtbl_pkg::*;

   logic [COUNT_BITS-1:0]  count_cap_ff;
   logic [SIZE_BITS-1:0]   size_cap_ff;
   logic [PERIOD_BITS-1:0] period_ff;
   logic [WAIT_BITS-1:0]   wait_lim_ff;
   reg_idx_type            csr_idx;
   logic                   csr_wr;

   logic                 in_valid_ff, in_valid_in;
   logic [1:0]           in_op_ff;
   logic                 in_has_size_ff;
   logic [SIZE_BITS-1:0] in_size_ff;

   logic        out_valid_ff, out_valid_in;
   verdict_type out_verdict_ff;
   verdict_type verdict;

   logic fire;
   logic is_request;
   logic load_out;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_cap_ff <= COUNT_BITS'(COUNT_RESET);
         size_cap_ff  <= '0;
         period_ff    <= PERIOD_BITS'(PERIOD_RESET);
         wait_lim_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_COUNT_CAP:  count_cap_ff <= csr_pwdata[COUNT_BITS-1:0];
            REG_SIZE_CAP:   size_cap_ff  <= csr_pwdata[SIZE_BITS-1:0];
            REG_PERIOD:     period_ff    <= csr_pwdata[PERIOD_BITS-1:0];
            REG_WAIT_LIMIT: wait_lim_ff  <= csr_pwdata[WAIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_COUNT_CAP:  csr_prdata = CSR_DATA_W'(count_cap_ff);
         REG_SIZE_CAP:   csr_prdata = CSR_DATA_W'(size_cap_ff);
         REG_PERIOD:     csr_prdata = CSR_DATA_W'(period_ff);
         REG_WAIT_LIMIT: csr_prdata = CSR_DATA_W'(wait_lim_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // stage handshake: only a request needs room in the result register
   assign is_request = (in_op_ff == OP_REQUEST);
   assign fire       = in_valid_ff && (!is_request || !out_valid_ff || rsp_tready);
   assign load_out   = fire && is_request;
   assign req_tready = !in_valid_ff || fire;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = load_out ? 1'b1 : (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff       <= req_tuser[1:0];
         in_has_size_ff <= req_tuser[2];
         in_size_ff     <= SIZE_BITS'(req_tdata);
      end
      if (load_out) begin
         out_verdict_ff <= verdict;
      end
   end

   dtbl_core #(
      .COUNT_BITS (COUNT_BITS),
      .SIZE_BITS  (SIZE_BITS),
      .TIME_BITS  (TIME_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .step_en          (fire),
      .op               (in_op_ff),
      .has_size         (in_has_size_ff),
      .request_size     (in_size_ff),
      .ops_limit        (count_cap_ff),
      .bytes_limit      (size_cap_ff),
      .refill_period_ms (period_ff),
      .wait_limit       (wait_lim_ff),
      .verdict          (verdict)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(out_verdict_ff.decision);
   assign rsp_tuser  = out_verdict_ff.forced_release;

endmodule

// ===== rtl/dtbl_core.sv =====
// ----------------------------------------------------------------------------
// dtbl_core
// Bucket state and the combinational grant/delay decision for one item.
// ----------------------------------------------------------------------------
module dtbl_core #(
   parameter int COUNT_BITS = dtbl_pkg::COUNT_BITS_DEF,
   parameter int SIZE_BITS  = dtbl_pkg::SIZE_BITS_DEF,
   parameter int TIME_BITS  = dtbl_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [1:0]                    op,
   input  logic                          has_size,
   input  logic [SIZE_BITS-1:0]          request_size,
   input  logic [COUNT_BITS-1:0]         ops_limit,
   input  logic [SIZE_BITS-1:0]          bytes_limit,
   input  logic [dtbl_pkg::PERIOD_BITS-1:0] refill_period_ms,
   input  logic [dtbl_pkg::WAIT_BITS-1:0]   wait_limit,
   output dtbl_pkg::verdict_type         verdict
);
   import dtbl_pkg::*;

   localparam int CMP_W = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;

   logic [COUNT_BITS-1:0] count_tokens_ff, count_tokens_in;
   logic [SIZE_BITS:0]    size_tokens_ff, size_tokens_in;
   logic [WAIT_BITS-1:0]  wait_count_ff, wait_count_in;
   logic [TIME_BITS-1:0]  elapsed_ms_ff, elapsed_ms_in;

   logic                  refill;
   logic                  size_pos;
   logic [COUNT_BITS-1:0] count_cur;
   logic [SIZE_BITS:0]    size_cap_ext;
   logic [SIZE_BITS:0]    size_cur;
   logic                  forced;
   logic                  delay;
   logic [SIZE_BITS+1:0]  size_diff;
   logic                  size_under;
   logic [SIZE_BITS:0]    size_debited;

   assign refill       = CMP_W'(elapsed_ms_ff) >= CMP_W'(refill_period_ms);
   assign size_cap_ext = {1'b0, bytes_limit};
   assign size_pos     = !size_tokens_ff[SIZE_BITS] && (|size_tokens_ff[SIZE_BITS-1:0]);
   assign count_cur    = refill ? ops_limit : count_tokens_ff;

   // a positive balance always clamps to the cap on refill, otherwise the sum fits
   assign size_cur = !refill ? size_tokens_ff :
                     size_pos ? size_cap_ext : size_tokens_ff + size_cap_ext;

   assign forced = refill && (wait_limit != '0) && (wait_count_ff == '0);
   assign delay  = !forced &&
                   (((ops_limit != '0) && (count_cur == '0)) ||
                    ((bytes_limit != '0) &&
                     (size_cur[SIZE_BITS] || (size_cur == '0))));

   // one extra bit so the debit can go below the floor before clamping
   assign size_diff    = {size_cur[SIZE_BITS], size_cur} - {2'b00, request_size};
   assign size_under   = size_diff[SIZE_BITS+1] && !size_diff[SIZE_BITS];
   assign size_debited = size_under ? {1'b1, {SIZE_BITS{1'b0}}} : size_diff[SIZE_BITS:0];

   assign verdict.decision       = delay;
   assign verdict.forced_release = forced;

   always_comb begin
      count_tokens_in = count_tokens_ff;
      size_tokens_in  = size_tokens_ff;
      wait_count_in   = wait_count_ff;
      elapsed_ms_in   = elapsed_ms_ff;
      case (op)
         OP_TICK: begin
            if (elapsed_ms_ff != '1) begin
               elapsed_ms_in = elapsed_ms_ff + TIME_BITS'(1);
            end
         end
         OP_REQUEST: begin
            count_tokens_in = count_cur;
            size_tokens_in  = size_cur;
            if (refill) begin
               elapsed_ms_in = '0;
            end
            if (delay) begin
               if (wait_count_ff != '0) begin
                  wait_count_in = wait_count_ff - WAIT_BITS'(1);
               end
            end else begin
               wait_count_in = wait_limit;
               if ((ops_limit != '0) && (count_cur != '0)) begin
                  count_tokens_in = count_cur - COUNT_BITS'(1);
               end
               if ((bytes_limit != '0) && has_size) begin
                  size_tokens_in = size_debited;
               end
            end
         end
         OP_RELOAD: begin
            count_tokens_in = ops_limit;
            size_tokens_in  = size_cap_ext;
            wait_count_in   = wait_limit;
            elapsed_ms_in   = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_tokens_ff <= COUNT_BITS'(COUNT_RESET);
         size_tokens_ff  <= '0;
         wait_count_ff   <= WAIT_BITS'(WAIT_RESET);
         elapsed_ms_ff   <= '0;
      end else if (step_en) begin
         count_tokens_ff <= count_tokens_in;
         size_tokens_ff  <= size_tokens_in;
         wait_count_ff   <= wait_count_in;
         elapsed_ms_ff   <= elapsed_ms_in;
      end
   end

`ifndef SYNTHESIS
   a_reload_fills: assert property (@(posedge clock) disable iff (reset)
      step_en && (op == OP_RELOAD) |=>
         (count_tokens_ff == $past(ops_limit)) && (elapsed_ms_ff == '0))
      else $error("reload did not refill the buckets");

   a_refill_clears_time: assert property (@(posedge clock) disable iff (reset)
      step_en && (op == OP_REQUEST) && refill |=> (elapsed_ms_ff == '0))
      else $error("refill did not clear elapsed time");

   a_grant_reloads_waits: assert property (@(posedge clock) disable iff (reset)
      step_en && (op == OP_REQUEST) && !delay |=> (wait_count_ff == $past(wait_limit)))
      else $error("grant did not reload the wait counter");
`endif

endmodule
